// ===== rtl/sad_pkg.sv =====
// ----------------------------------------------------------------------------
// SAD alignment search package
// Shared widths, limits, codes and interface types of the alignment search.
// ----------------------------------------------------------------------------
`default_nettype none

package sad_pkg;

  // Limits of the stores.
  localparam int MAX_WINDOW  = 2048;
  localparam int MAX_RADIUS  = 512;
  localparam int TRACE_DEPTH = MAX_WINDOW + 2 * MAX_RADIUS;

  // Field and register widths.
  localparam int SAMPLE_W = 8;
  localparam int WIN_W    = 12;
  localparam int RAD_W    = 10;
  localparam int SHIFT_W  = 10;
  localparam int COST_W   = 19;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Derived widths.
  localparam int REF_AW   = $clog2(MAX_WINDOW);
  localparam int TRACE_AW = $clog2(TRACE_DEPTH);
  localparam int REFC_W   = $clog2(MAX_WINDOW + 1);
  localparam int TRC_W    = $clog2(TRACE_DEPTH + 1);
  localparam int WCL_W    = $clog2(MAX_WINDOW + 1);
  localparam int RADC_W   = $clog2(MAX_RADIUS + 1);
  localparam int SIDX_W   = $clog2(2 * MAX_RADIUS);

  localparam logic [COST_W-1:0] COST_ONES = '1;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1400);
  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(500);

  // Input operation codes.
  typedef enum logic {
    OP_REF   = 1'b0,
    OP_TRACE = 1'b1
  } sad_op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_RADIUS = 1'b1
  } sad_cfg_idx_t;

  // Search sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } sad_state_t;

  // Status of the search engine toward the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } sad_status_t;

  // Result of one search.
  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift;
    logic [COST_W-1:0]         cost;
  } sad_result_t;

endpackage

`default_nettype wire

// ===== rtl/sad_shift_alignment_search.sv =====
// ----------------------------------------------------------------------------
// SAD shift alignment search
// Loads a reference window and a candidate trace into sample RAMs and finds
// the shift with the smallest sum of absolute wrapped differences.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_stall    opcode, sample, last
//  out      source     out_valid / out_stall  best_shift, best_cost
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A reference or trace sample is taken one per cycle while the search engine is idle.
//  A trace sample with last set starts a search that reads 2 * radius * window
//  term pairs from the clamped settings, one RAM read pair per cycle, then
//  drains the pipeline and hands the result over. The result is offered once
//  the search is done, or without any term read when the window or the radius
//  is zero, and the input stalls until the result is handed over.
//  Reset clears the sample counts and restores window 1400 and radius 500;
//  the sample RAMs are not cleared. A result that cannot enter the stalled
//  output register waits in the search engine, which keeps the input stalled.
//
`default_nettype none

module sad_shift_alignment_search (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input transactions.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            opcode,
  input  wire logic signed [sad_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                            last,
  // Result transactions.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [sad_pkg::SHIFT_W-1:0]   best_shift,
  output logic        [sad_pkg::COST_W-1:0]    best_cost,
  // Configuration writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [sad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sad_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sad_pkg::*;

  logic [WIN_W-1:0]  window_length;
  logic [RAD_W-1:0]  shift_radius;
  logic [REFC_W-1:0] ref_count;
  logic [TRC_W-1:0]  trace_count;

  logic in_acc, ref_we, trace_we, start, res_take;

  logic [REF_AW-1:0]   ref_raddr;
  logic [TRACE_AW-1:0] trace_raddr;
  logic [SAMPLE_W-1:0] ref_rdata, trace_rdata;

  sad_status_t status;
  sad_result_t result;

  // Input transaction decode.
  always_comb begin
    in_stall  = status.busy;
    cfg_ready = 1'b1;
    in_acc    = in_valid && !in_stall;
    ref_we    = in_acc && (opcode == OP_REF) && (ref_count < REFC_W'(MAX_WINDOW));
    trace_we  = in_acc && (opcode == OP_TRACE) && (trace_count < TRC_W'(TRACE_DEPTH));
    start     = in_acc && (opcode == OP_TRACE) && last;
    res_take  = status.done && (!out_valid || !out_stall);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      shift_radius  <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW: window_length <= WIN_W'(cfg_data);
        CFG_RADIUS: shift_radius  <= RAD_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Sample counts; the trace restarts after every search.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count   <= '0;
      trace_count <= '0;
    end else begin
      if (ref_we) begin
        ref_count <= ref_count + REFC_W'(1);
      end
      if (start) begin
        trace_count <= '0;
      end else if (trace_we) begin
        trace_count <= trace_count + TRC_W'(1);
      end
    end
  end

  // Reference sample store.
  sad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_count[REF_AW-1:0]),
    .wdata (sample),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  // Trace sample store.
  sad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TRACE_DEPTH)
  ) u_trace_ram (
    .clk   (clk),
    .we    (trace_we),
    .waddr (trace_count[TRACE_AW-1:0]),
    .wdata (sample),
    .raddr (trace_raddr),
    .rdata (trace_rdata)
  );

  // Search engine.
  sad_search u_search (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .ack           (res_take),
    .window_length (window_length),
    .shift_radius  (shift_radius),
    .ref_addr      (ref_raddr),
    .trace_addr    (trace_raddr),
    .ref_data      (ref_rdata),
    .trace_data    (trace_rdata),
    .status        (status),
    .result        (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      best_shift <= result.shift;
      best_cost  <= result.cost;
    end
  end

`ifndef SYNTH
  // A trace sample marked last always starts a search.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> status.busy)
    else $error("search did not start after the last trace sample");

  // A result handed over is offered on the output next cycle.
  a_take_out: assert property (@(posedge clk) disable iff (rst)
    res_take |=> out_valid)
    else $error("taken result not presented on the output");

  // The sample counts never pass the store depths.
  a_ref_count: assert property (@(posedge clk) disable iff (rst)
    ref_count <= REFC_W'(MAX_WINDOW))
    else $error("reference count beyond the store depth");

  a_trace_count: assert property (@(posedge clk) disable iff (rst)
    trace_count <= TRC_W'(TRACE_DEPTH))
    else $error("trace count beyond the store depth");
`endif

endmodule

`default_nettype wire

// ===== rtl/sad_ram.sv =====
// ----------------------------------------------------------------------------
// Generic sample RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sad_search.sv =====
// ----------------------------------------------------------------------------
// SAD search engine
// Walks every shift and window position through the two sample RAMs, one
// term per cycle, accumulates the absolute wrapped differences and keeps the
// earliest shift with the smallest sum.
// ----------------------------------------------------------------------------
`default_nettype none

module sad_search (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          ack,
  input  wire logic [sad_pkg::WIN_W-1:0]     window_length,
  input  wire logic [sad_pkg::RAD_W-1:0]     shift_radius,
  output logic      [sad_pkg::REF_AW-1:0]    ref_addr,
  output logic      [sad_pkg::TRACE_AW-1:0]  trace_addr,
  input  wire logic [sad_pkg::SAMPLE_W-1:0]  ref_data,
  input  wire logic [sad_pkg::SAMPLE_W-1:0]  trace_data,
  output sad_pkg::sad_status_t               status,
  output sad_pkg::sad_result_t               result
);
  import sad_pkg::*;

  sad_state_t state, state_next;

  // Clamped limits of the running search.
  logic [WCL_W-1:0]  w_clamp, w_lim;
  logic [RADC_W-1:0] r_clamp, r_lim;

  // Issue counters.
  logic [REF_AW-1:0] k;
  logic [SIDX_W-1:0] s;
  logic              k_last, s_last, issue;

  // Read stage tags, aligned with RAM data.
  logic              rd_valid, rd_first, rd_last, rd_final;
  logic [SIDX_W-1:0] rd_shift;

  // Accumulate stage.
  logic [SAMPLE_W-1:0] diff, term;
  logic [COST_W-1:0]   acc, acc_sum;

  // Compare stage.
  logic              sum_valid, sum_final;
  logic [SIDX_W-1:0] sum_shift;
  logic [COST_W-1:0] sum_cost;
  logic [COST_W-1:0] best_cost, best_cost_next;
  logic [SIDX_W-1:0] best_idx, best_idx_next;
  logic              better;

  logic signed [SHIFT_W-1:0] res_shift;
  logic [COST_W-1:0]         res_cost;

  // Clamp the configured window and radius to the store limits.
  always_comb begin
    w_clamp = (32'(window_length) > MAX_WINDOW) ? WCL_W'(MAX_WINDOW) : WCL_W'(window_length);
    r_clamp = (32'(shift_radius) > MAX_RADIUS) ? RADC_W'(MAX_RADIUS) : RADC_W'(shift_radius);
  end

  // Addresses and end-of-loop flags of the issue stage.
  always_comb begin
    issue      = (state == S_RUN);
    ref_addr   = k;
    trace_addr = TRACE_AW'(k) + TRACE_AW'(s);
    k_last     = (WCL_W'(k) == (w_lim - WCL_W'(1)));
    s_last     = ((RADC_W + 1)'(s) == ({r_lim, 1'b0} - (RADC_W + 1)'(1)));
  end

  // Absolute wrapped difference and running sum.
  always_comb begin
    diff    = ref_data - trace_data;
    term    = diff[SAMPLE_W-1] ? (~diff + SAMPLE_W'(1)) : diff;
    acc_sum = (rd_first ? '0 : acc) + COST_W'(term);
  end

  // Strictly smaller sums win, so the earliest shift keeps a tie.
  always_comb begin
    better         = sum_valid && (sum_cost < best_cost);
    best_cost_next = better ? sum_cost : best_cost;
    best_idx_next  = better ? sum_shift : best_idx;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and status.
  always_comb begin
    state_next  = state;
    status.busy = (state != S_IDLE);
    status.done = (state == S_DONE);
    case (state)
      S_IDLE: begin
        if (start) begin
          if (r_clamp == '0 || w_clamp == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (k_last && s_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sum_valid && sum_final) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      rd_valid  <= issue;
      sum_valid <= rd_valid && rd_last;
    end
  end

  // Counters, tags, sums and the running best.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      w_lim     <= w_clamp;
      r_lim     <= r_clamp;
      k         <= '0;
      s         <= '0;
      best_cost <= COST_ONES;
      best_idx  <= '0;
      // A zero radius searches nothing; a zero window makes every sum zero.
      if (r_clamp == '0) begin
        res_shift <= '0;
        res_cost  <= COST_ONES;
      end else begin
        res_shift <= SHIFT_W'((RADC_W + 1)'(0) - (RADC_W + 1)'(r_clamp));
        res_cost  <= '0;
      end
    end else begin
      if (issue) begin
        if (k_last) begin
          k <= '0;
          if (!s_last) begin
            s <= s + SIDX_W'(1);
          end
        end else begin
          k <= k + REF_AW'(1);
        end
      end
      if (sum_valid) begin
        best_cost <= best_cost_next;
        best_idx  <= best_idx_next;
        if (sum_final) begin
          res_cost  <= best_cost_next;
          res_shift <= SHIFT_W'((RADC_W + 1)'(best_idx_next) - (RADC_W + 1)'(r_lim));
        end
      end
    end

    rd_first <= (k == '0);
    rd_last  <= k_last;
    rd_final <= k_last && s_last;
    rd_shift <= s;

    if (rd_valid) begin
      acc <= acc_sum;
    end
    sum_cost  <= acc_sum;
    sum_final <= rd_final;
    sum_shift <= rd_shift;
  end

  assign result.shift = res_shift;
  assign result.cost  = res_cost;

endmodule

`default_nettype wire

// ===== tb/sv/sad_alignment_checker.sv =====
// ----------------------------------------------------------------------------
// SAD alignment search checker
// Watches the input, result and register channels of the alignment search,
// keeps its own copy of the sample stores and registers, predicts each search
// result and compares every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sad_alignment_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                opcode,
  input  logic signed [sad_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [sad_pkg::SHIFT_W-1:0]  best_shift,
  input  logic        [sad_pkg::COST_W-1:0]   best_cost,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [sad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sad_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  checked
);
  import sad_pkg::*;

  localparam int MAX_REPORTS = 30;

  // Shadow copy of the block state.
  logic signed [SAMPLE_W-1:0] ref_samples   [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] trace_samples [TRACE_DEPTH];
  int unsigned                ref_count;
  int unsigned                trace_count;
  logic [WIN_W-1:0]           win_len;
  logic [RAD_W-1:0]           radius;

  // Predicted search results, oldest first.
  sad_result_t search_results_q [$];

  // Entries that are never written read as zero in the shadow stores.
  initial begin
    foreach (ref_samples[i]) ref_samples[i] = '0;
    foreach (trace_samples[i]) trace_samples[i] = '0;
  end

  // Print one line per mismatch, up to a cap, and count all of them.
  task automatic report(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: mismatch: %s", $time, what);
    else if (mismatches == MAX_REPORTS + 1)
      $display("further mismatches are counted but not printed");
  endtask

  // Score every shift of the current trace against the reference window and
  // keep the cheapest one; a later shift must be strictly cheaper to win.
  function automatic sad_result_t align_search();
    int                         w;
    int                         r;
    int                         n;
    int                         k;
    int                         pos;
    int                         mag;
    int unsigned                sum;
    logic signed [SAMPLE_W-1:0] t;
    logic signed [SAMPLE_W-1:0] d;
    sad_result_t                res;
    w = (win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
    r = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
    res.shift = '0;
    res.cost  = COST_ONES;
    for (n = -r; n < r; n++) begin
      sum = 0;
      for (k = 0; k < w; k++) begin
        pos = k + n + r;
        t   = (pos < TRACE_DEPTH) ? trace_samples[pos] : '0;
        // The difference wraps to 8 bits, so each term lies in 0..128.
        d   = ref_samples[k] - t;
        mag = int'(d);
        sum += (mag < 0) ? -mag : mag;
      end
      if (sum < res.cost) begin
        res.cost  = sum[COST_W-1:0];
        res.shift = n[SHIFT_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    sad_result_t want;
    if (rst) begin
      ref_count   = 0;
      trace_count = 0;
      win_len     = WINDOW_RESET;
      radius      = RADIUS_RESET;
      search_results_q.delete();
    end else begin
      // Result transaction: compare with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (search_results_q.size() == 0) begin
          report($sformatf("result with nothing pending: shift %0d cost %0d",
                           best_shift, best_cost));
        end else begin
          want = search_results_q.pop_front();
          checked++;
          if (best_shift !== want.shift)
            report($sformatf("search %0d: best_shift %0d, predicted %0d",
                             checked, best_shift, want.shift));
          if (best_cost !== want.cost)
            report($sformatf("search %0d: best_cost %0d, predicted %0d",
                             checked, best_cost, want.cost));
        end
      end

      // Input transaction: store the sample; a closing trace sample searches.
      if (in_valid && !in_stall) begin
        if (sad_op_t'(opcode) == OP_REF) begin
          // The last bit of a reference sample has no effect.
          if (ref_count < MAX_WINDOW) begin
            ref_samples[ref_count] = sample;
            ref_count++;
          end
        end else begin
          // A sample that finds the store full is dropped, but its last
          // bit still starts the search.
          if (trace_count < TRACE_DEPTH) begin
            trace_samples[trace_count] = sample;
            trace_count++;
          end
          if (last) begin
            search_results_q = {search_results_q, align_search()};
            trace_count = 0;
          end
        end
      end

      // Register write transaction.
      if (cfg_valid && cfg_ready) begin
        case (sad_cfg_idx_t'(cfg_index))
          CFG_WINDOW: win_len = cfg_data[WIN_W-1:0];
          CFG_RADIUS: radius  = cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
    end
    pending = search_results_q.size();
  end

endmodule

// ===== tb/sv/sad_shift_alignment_search_test.sv =====
// ----------------------------------------------------------------------------
// SAD shift alignment search testbench
// Loads reference and trace samples with bursty input timing and a random
// output stall pattern, sweeps window and radius through their extremes and
// random small settings, and lets the checker compare every search result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sad_shift_alignment_search_test;
  import sad_pkg::*;

  localparam int TOTAL_ITEMS   = 950;
  localparam int DIRECTED_REFS = 24;
  localparam int PREFILL_TRACE = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 32;
  localparam int IDLE_LIMIT    = 20000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        opcode = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample = '0;
  logic                        last = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SHIFT_W-1:0]   best_shift;
  logic        [COST_W-1:0]    best_cost;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  int mismatches;
  int pending;
  int checked;

  // Stimulus bookkeeping.
  int burst_left = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int stall_run = 0;
  bit stall_on = 1'b0;
  logic signed [SAMPLE_W-1:0] ref_seed [DIRECTED_REFS];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  sad_shift_alignment_search u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .sample     (sample),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_shift (best_shift),
    .best_cost  (best_cost),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sad_alignment_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .sample     (sample),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_shift (best_shift),
    .best_cost  (best_cost),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // Result side: alternate stall and free runs, with rare long stall and free stretches.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_on = !stall_on;
        if (stall_on)
          stall_run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 4);
        else
          stall_run = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      stall_run--;
      out_stall <= stall_on;
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sample values with the extremes and the values near zero favored.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return -8'sd128;
      1:       return 8'sd127;
      2:       return 8'sd0;
      3:       return -8'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Present one input transaction and hold it until it is taken. The sender
  // works in bursts; a new burst may open with a gap.
  task automatic send_item(sad_op_t op, logic signed [SAMPLE_W-1:0] s, logic is_last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(30, 80);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 10);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode   <= op;
    sample   <= s;
    last     <= is_last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Trace of random samples; the final one closes it. Noisy traces carry
  // stray reference samples, whose last bit must be ignored.
  task automatic send_trace(int len, bit noisy);
    int i;
    for (i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_item(OP_REF, pick_sample(), 1'($urandom_range(0, 1)));
      send_item(OP_TRACE, pick_sample(), i == len - 1);
    end
  endtask

  // Wait until every search result is out and the block has settled, then
  // write both registers back to back.
  task automatic write_config(logic [WIN_W-1:0] win, logic [RAD_W-1:0] rad);
    int i;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    for (i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_WINDOW : CFG_RADIUS;
      cfg_data  <= (i == 0) ? CFG_DATA_W'(win) : CFG_DATA_W'(rad);
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int               i;
    int               len;
    int               span;
    int               eff_w;
    int               eff_r;
    bit               big;
    logic [WIN_W-1:0] w;
    logic [RAD_W-1:0] r;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed reference window: extremes first, one carrying a stray last.
    ref_seed[0] = -8'sd128;
    ref_seed[1] = 8'sd127;
    ref_seed[2] = 8'sd0;
    ref_seed[3] = -8'sd1;
    ref_seed[4] = 8'sd1;
    ref_seed[5] = 8'sd64;
    for (i = 6; i < DIRECTED_REFS; i++) ref_seed[i] = pick_sample();
    write_config(WIN_W'(16), RAD_W'(4));
    for (i = 0; i < DIRECTED_REFS; i++) send_item(OP_REF, ref_seed[i], i == 5);

    // Full trace with the reference inverted in its sign bit at shift zero,
    // so that every term there wraps to the largest cost.
    for (i = 0; i < 24; i++) begin
      if (i == 0)
        send_item(OP_TRACE, 8'sd127, 1'b0);
      else if (i == 1)
        send_item(OP_TRACE, -8'sd128, 1'b0);
      else if (i >= 4 && i < 20)
        send_item(OP_TRACE, ref_seed[i - 4] ^ 8'h80, 1'b0);
      else
        send_item(OP_TRACE, pick_sample(), i == 23);
    end

    // Smallest radius with the reference copied in at shift zero.
    write_config(WIN_W'(16), RAD_W'(1));
    send_item(OP_TRACE, pick_sample(), 1'b0);
    for (i = 0; i < 16; i++) send_item(OP_TRACE, ref_seed[i], i == 15);

    // Zero window: all shifts tie at zero and the earliest one wins.
    write_config(WIN_W'(0), RAD_W'(3));
    send_item(OP_TRACE, pick_sample(), 1'b1);

    // Zero radius: nothing is searched.
    write_config(WIN_W'(16), RAD_W'(0));
    send_trace(2, 1'b0);

    // Short trace: the search reads samples left from earlier traces.
    write_config(WIN_W'(16), RAD_W'(4));
    send_trace(3, 1'b0);

    // Overlong trace.
    write_config(WIN_W'(16), RAD_W'(2));
    send_trace(30, 1'b0);

    // Write the part of both stores that the random rounds read: 48
    // reference samples and a trace past the widest random span.
    for (i = DIRECTED_REFS; i < 2 * DIRECTED_REFS; i++)
      send_item(OP_REF, pick_sample(), 1'($urandom_range(0, 1)));
    write_config(WIN_W'(48), RAD_W'(24));
    send_trace(PREFILL_TRACE, 1'b0);

    // Random rounds: mostly small settings and well-formed traces, with
    // short, long and noisy traces mixed in. Settings beyond the limits come
    // with nothing to read, so every search reads only written entries.
    while (items_sent < TOTAL_ITEMS) begin
      w   = WIN_W'($urandom_range(16, 48));
      r   = RAD_W'($urandom_range(1, 8));
      big = 1'b0;
      case ($urandom_range(0, 39))
        0, 1:    w = '0;
        2, 3:    w = WIN_W'($urandom_range(1, 15));
        4: begin
          // Window above its limit with a zero radius.
          w   = WIN_W'($urandom_range(MAX_WINDOW, 4095));
          r   = '0;
          big = 1'b1;
        end
        5: begin
          // Radius near and above its limit with a zero window.
          w   = '0;
          r   = RAD_W'($urandom_range(MAX_RADIUS - 2, 1023));
          big = 1'b1;
        end
        6, 7:    r = '0;
        8, 9:    r = RAD_W'($urandom_range(9, 24));
        default: ;
      endcase
      eff_w = (w > MAX_WINDOW) ? MAX_WINDOW : int'(w);
      eff_r = (r > MAX_RADIUS) ? MAX_RADIUS : int'(r);
      span  = eff_w + 2 * eff_r;
      if (span < 1) span = 1;
      if (big)
        len = $urandom_range(1, 6);
      else begin
        case ($urandom_range(0, 19))
          0, 1, 2: len = (span > 1) ? $urandom_range(1, span - 1) : 1;
          3, 4, 5: len = span + $urandom_range(1, 8);
          default: len = span;
        endcase
      end
      write_config(w, r);
      send_trace(len, $urandom_range(0, 2) == 0);
    end

    // Let every result come out and the block go quiet.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending != 0)
      $display("%0d search results never arrived", pending);
    $display("Sent %0d input transactions and %0d register writes; checked %0d searches.",
             items_sent, cfg_writes, checked);
    $display("Covered zero and out-of-range window and radius, stale, long and noisy traces.");
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sad_pkg.sv
rtl/sad_ram.sv
rtl/sad_search.sv
rtl/sad_shift_alignment_search.sv
tb/sv/sad_alignment_checker.sv
tb/sv/sad_shift_alignment_search_test.sv
